// ===== hdl/imd_pkg.sv =====
// Shared types, constants and lookup functions for the ICY metadata demux.
// No dependencies; imported by every module of the block.
`default_nettype none
package imd_pkg;

  localparam int META_BUFFER_BYTES = 4096;
  localparam int META_POS_W        = 12;
  localparam int META_REM_W        = 12;
  localparam int AUDIO_W           = 16;
  localparam int RES_MAX           = 3;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int KEY_LEN           = 13;

  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_TITLE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef struct packed {
    logic [1:0]                  cnt;
    logic [RES_MAX-1:0][1:0]     kind;
    logic [RES_MAX-1:0][7:0]     data;
  } bundle_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = 8'h73;
      4'd1:  ch = 8'h74;
      4'd2:  ch = 8'h72;
      4'd3:  ch = 8'h65;
      4'd4:  ch = 8'h61;
      4'd5:  ch = 8'h6d;
      4'd6:  ch = 8'h74;
      4'd7:  ch = 8'h69;
      4'd8:  ch = 8'h74;
      4'd9:  ch = 8'h6c;
      4'd10: ch = 8'h65;
      4'd11: ch = 8'h3d;
      4'd12: ch = 8'h27;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/imd_front.sv =====
// Front end: config register, stream framing and title matcher.
// Classifies each accepted byte into a bundle of up to three result words.
// Depends on imd_pkg.
`default_nettype none
module imd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  input  wire logic                push,
  input  wire logic [7:0]          in_stream_byte,
  input  wire logic                fifo_full,
  output logic                     fifo_wr,
  output imd_pkg::bundle_t         fifo_wdata
);
  import imd_pkg::*;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_TITLE  = 2'd1;
  localparam logic [1:0] PH_OVER   = 2'd2;
  localparam logic [1:0] PH_DEAD   = 2'd3;

  logic [AUDIO_W-1:0]    interval_r, interval_nxt;
  logic [AUDIO_W-1:0]    audio_rem_r, audio_rem_nxt;
  logic [META_REM_W-1:0] meta_rem_r, meta_rem_nxt;
  logic [META_POS_W-1:0] meta_pos_r, meta_pos_nxt;
  logic [3:0]            kmc_r, kmc_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic                  qp_r, qp_nxt;

  logic                  cfg_we;
  logic                  accept;
  logic [7:0]            c;
  logic [7:0]            lc;
  logic [1:0]            n;
  bundle_t               b;

  assign cfg_we = psel && penable && pwrite;
  assign accept = push && !fifo_full;
  assign c      = in_stream_byte;
  assign lc     = to_lower(in_stream_byte);
  assign prdata = {{(32-AUDIO_W){1'b0}}, interval_r};

  always_comb begin
    interval_nxt  = interval_r;
    audio_rem_nxt = audio_rem_r;
    meta_rem_nxt  = meta_rem_r;
    meta_pos_nxt  = meta_pos_r;
    kmc_nxt       = kmc_r;
    phase_nxt     = phase_r;
    qp_nxt        = qp_r;
    n             = 2'd0;
    b             = '0;
    if (cfg_we) begin
      interval_nxt  = pwdata[AUDIO_W-1:0];
      audio_rem_nxt = pwdata[AUDIO_W-1:0];
      meta_rem_nxt  = '0;
      meta_pos_nxt  = '0;
      kmc_nxt       = '0;
      phase_nxt     = PH_SEARCH;
      qp_nxt        = 1'b0;
    end else if (accept) begin
      if (interval_r == '0) begin
        b.kind[n] = KIND_AUDIO;
        b.data[n] = c;
        n = n + 2'd1;
      end else if (audio_rem_r != '0) begin
        audio_rem_nxt = audio_rem_r - 1'b1;
        b.kind[n] = KIND_AUDIO;
        b.data[n] = c;
        n = n + 2'd1;
      end else if (meta_rem_r == '0) begin
        if (c == CH_NUL) begin
          audio_rem_nxt = interval_r;
        end else begin
          meta_rem_nxt = {c, 4'b0000};
          meta_pos_nxt = '0;
          kmc_nxt      = '0;
          phase_nxt    = PH_SEARCH;
          qp_nxt       = 1'b0;
        end
      end else begin
        if (meta_pos_r < META_POS_W'(META_BUFFER_BYTES - 1)) begin
          meta_pos_nxt = meta_pos_r + 1'b1;
          case (phase_r)
            PH_SEARCH: begin
              if (c == CH_NUL) begin
                phase_nxt = PH_DEAD;
              end else begin
                if (kmc_r < 4'(KEY_LEN) && lc == key_char(kmc_r)) begin
                  kmc_nxt = kmc_r + 4'd1;
                end else begin
                  kmc_nxt = (lc == key_char(4'd0)) ? 4'd1 : 4'd0;
                end
                if (kmc_nxt >= 4'(KEY_LEN)) begin
                  kmc_nxt   = 4'd0;
                  phase_nxt = PH_TITLE;
                end
              end
            end
            PH_TITLE: begin
              if (c == CH_NUL) begin
                phase_nxt = PH_OVER;
                qp_nxt    = 1'b0;
              end else if (qp_r && c == CH_SEMI) begin
                phase_nxt = PH_OVER;
                qp_nxt    = 1'b0;
              end else begin
                if (qp_r) begin
                  b.kind[n] = KIND_TITLE;
                  b.data[n] = CH_QUOTE;
                  n = n + 2'd1;
                end
                if (c == CH_QUOTE) begin
                  qp_nxt = 1'b1;
                end else begin
                  qp_nxt = 1'b0;
                  b.kind[n] = KIND_TITLE;
                  b.data[n] = c;
                  n = n + 2'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        meta_rem_nxt = meta_rem_r - 1'b1;
        if (meta_rem_r == META_REM_W'(1)) begin
          if (phase_nxt == PH_TITLE || phase_nxt == PH_OVER) begin
            b.kind[n] = KIND_DONE;
            b.data[n] = 8'h00;
            n = n + 2'd1;
          end
          meta_pos_nxt  = '0;
          kmc_nxt       = '0;
          phase_nxt     = PH_SEARCH;
          qp_nxt        = 1'b0;
          audio_rem_nxt = interval_r;
        end
      end
    end
    b.cnt = n;
  end

  assign fifo_wr    = accept && !cfg_we && (n != 2'd0);
  assign fifo_wdata = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= '0;
      audio_rem_r <= '0;
      meta_rem_r  <= '0;
      meta_pos_r  <= '0;
      kmc_r       <= '0;
      phase_r     <= PH_SEARCH;
      qp_r        <= 1'b0;
    end else begin
      interval_r  <= interval_nxt;
      audio_rem_r <= audio_rem_nxt;
      meta_rem_r  <= meta_rem_nxt;
      meta_pos_r  <= meta_pos_nxt;
      kmc_r       <= kmc_nxt;
      phase_r     <= phase_nxt;
      qp_r        <= qp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/imd_fifo.sv =====
// Short bundle queue between the front end and the result serializer.
// Depends on imd_pkg.
`default_nettype none
module imd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr,
  input  imd_pkg::bundle_t   wdata,
  input  wire logic          rd,
  output logic               full,
  output logic               nonempty,
  output imd_pkg::bundle_t   rdata
);
  import imd_pkg::*;

  bundle_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt;
  logic [FIFO_PTR_W-1:0] rp_r, rp_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;
  logic                  do_wr;
  logic                  do_rd;

  assign full     = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rdata    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/imd_back.sv =====
// Back end: splits queued bundles into single result words behind an output register.
// Depends on imd_pkg.
`default_nettype none
module imd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  imd_pkg::bundle_t   head,
  output logic               head_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_data,
  output logic               out_last_of_run
);
  import imd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       is_last;

  assign load    = head_valid && (!valid_r || pop);
  assign is_last = (idx_r == head.cnt - 2'd1);

  always_comb begin
    valid_nxt = valid_r && !pop;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    head_pop  = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      kind_nxt  = head.kind[idx_r];
      data_nxt  = head.data[idx_r];
      last_nxt  = is_last;
      if (is_last) begin
        idx_nxt  = 2'd0;
        head_pop = 1'b1;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign empty           = !valid_r;
  assign out_kind        = kind_r;
  assign out_data        = data_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire

// ===== hdl/icy_metadata_demux.sv =====
// ICY metadata demux top level: front end, bundle queue and result serializer.
// Depends on imd_pkg, imd_front, imd_fifo and imd_back.
//
// Usage:
//   Stream bytes enter on push/full; a word is taken when push is high and full low.
//   Results leave on empty/pop: while empty is low the oldest result word is on
//   out_kind/out_data/out_last_of_run and is taken when pop is high.
//   Each input byte yields zero to three result words (audio, title bytes, title
//   complete); out_last_of_run marks the final word caused by one input byte.
//   An accepted byte passes through the bundle queue and then the output register
//   before its first word is on the output. Throughput is one byte per cycle while
//   full is low, with a four-entry queue absorbing bytes that yield several words.
//   When pop stays low the queue fills and full rises; no word is lost.
//   The APB port holds audio_interval at address 0 (paddr ignored); writing it
//   restarts framing and must only happen while the block is idle.
//   Synchronous reset clears the interval to zero (all bytes pass as audio),
//   empties the queue and the output register.
`default_nettype none
module icy_metadata_demux (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic             out_last_of_run
);
  import imd_pkg::*;

  logic    fifo_full;
  logic    fifo_wr;
  bundle_t fifo_wdata;
  logic    fifo_nonempty;
  bundle_t fifo_head;
  logic    fifo_rd;
  logic    addr_unused;

  assign pready      = 1'b1;
  assign full        = fifo_full;
  assign addr_unused = ^paddr;

  imd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite && (addr_unused || !addr_unused)),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .push           (push),
    .in_stream_byte (in_stream_byte),
    .fifo_full      (fifo_full),
    .fifo_wr        (fifo_wr),
    .fifo_wdata     (fifo_wdata)
  );

  imd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (fifo_wr),
    .wdata    (fifo_wdata),
    .rd       (fifo_rd),
    .full     (fifo_full),
    .nonempty (fifo_nonempty),
    .rdata    (fifo_head)
  );

  imd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (fifo_nonempty),
    .head            (fifo_head),
    .head_pop        (fifo_rd),
    .pop             (pop),
    .empty           (empty),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_last_of_run (out_last_of_run)
  );

  a_done_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_DONE) |-> (out_data == 8'h00 && out_last_of_run))
    else $error("title complete word not final or carries data");

  a_audio_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_AUDIO) |-> out_last_of_run)
    else $error("audio word not marked last of run");

  a_run_continues_title: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last_of_run) |-> out_kind == KIND_TITLE)
    else $error("non-final word of a run is not a title byte");

  a_queue_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_nonempty && empty) |=> !empty)
    else $error("queued bundle did not reach the output register");

endmodule
`default_nettype wire

// ===== tb/imd_stream_checker.sv =====
// Checker for the ICY metadata demux: tracks the stream framing and title matcher,
// predicts the output words of every accepted byte and compares them in order.
// Depends on imd_pkg for the result kinds, the special characters and the sizes.
`timescale 1ns / 100ps
module imd_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        pop,
  input  wire logic        empty,
  input  wire logic [1:0]  out_kind,
  input  wire logic [7:0]  out_data,
  input  wire logic        out_last_of_run,
  output int               n_pending,
  output int               n_fail,
  output int               n_checked,
  output int               n_done
);
  import imd_pkg::*;

  localparam logic [8*KEY_LEN-1:0] TITLE_KEY = "streamtitle='";

  typedef enum logic [1:0] {SEEK_KEY, IN_TITLE, TITLE_ENDED, NO_KEY} title_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last_of_run;
  } word_t;

  word_t        expected_words[$];
  word_t        fresh[$];
  int           fails;
  int           checked;
  int           done_seen;

  logic [15:0]  interval;
  logic [15:0]  audio_todo;
  logic         want_length;
  logic [11:0]  block_todo;
  logic [11:0]  block_seen;
  logic [3:0]   key_hits;
  title_state_t title_state;
  logic         quote_held;

  function automatic logic [7:0] key_at(input int idx);
    return TITLE_KEY[8*(KEY_LEN-1-idx) +: 8];
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] data);
    fresh.push_back('{kind, data, 1'b0});
  endfunction

  function automatic void restart_scan();
    block_seen  = '0;
    key_hits    = '0;
    title_state = SEEK_KEY;
    quote_held  = 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] c;
    logic [7:0] lc;
    word_t      want;
    if (!rst_n) begin
      interval    = '0;
      audio_todo  = '0;
      want_length = 1'b1;
      block_todo  = '0;
      restart_scan();
      expected_words.delete();
      fails       = 0;
      checked     = 0;
      done_seen   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        interval    = pwdata[15:0];
        audio_todo  = pwdata[15:0];
        want_length = 1'b1;
        block_todo  = '0;
        restart_scan();
      end
      if (pop && !empty) begin
        checked++;
        if (out_kind == KIND_DONE) done_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected out word: out_kind %0d out_data %02h", out_kind, out_data);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            fails++;
          end
          if (out_data !== want.data) begin
            $error("out_data: expected %02h, got %02h", want.data, out_data);
            fails++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("out_last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_last_of_run);
            fails++;
          end
        end
      end
      if (push && !full) begin
        c = in_stream_byte;
        fresh.delete();
        if (interval == 0) begin
          emit(KIND_AUDIO, c);
        end else if (audio_todo != 0) begin
          audio_todo--;
          emit(KIND_AUDIO, c);
        end else if (want_length || block_todo == 0) begin
          if (c == CH_NUL) begin
            audio_todo  = interval;
            want_length = 1'b1;
          end else begin
            block_todo  = {c, 4'h0};
            want_length = 1'b0;
            restart_scan();
          end
        end else begin
          if (block_seen < META_BUFFER_BYTES - 1) begin
            block_seen++;
            lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
            case (title_state)
              SEEK_KEY: begin
                if (c == CH_NUL) begin
                  title_state = NO_KEY;
                end else begin
                  if (key_hits < KEY_LEN && lc == key_at(key_hits)) key_hits++;
                  else key_hits = (lc == key_at(0)) ? 4'd1 : 4'd0;
                  if (key_hits >= KEY_LEN) begin
                    key_hits    = '0;
                    title_state = IN_TITLE;
                  end
                end
              end
              IN_TITLE: begin
                if (c == CH_NUL || (quote_held && c == CH_SEMI)) begin
                  title_state = TITLE_ENDED;
                  quote_held  = 1'b0;
                end else begin
                  if (quote_held) emit(KIND_TITLE, CH_QUOTE);
                  quote_held = (c == CH_QUOTE);
                  if (c != CH_QUOTE) emit(KIND_TITLE, c);
                end
              end
              default: ;
            endcase
          end
          block_todo--;
          if (block_todo == 0) begin
            if (title_state == IN_TITLE || title_state == TITLE_ENDED) emit(KIND_DONE, 8'h00);
            restart_scan();
            audio_todo  = interval;
            want_length = 1'b1;
          end
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last_of_run = 1'b1;
        foreach (fresh[i]) expected_words.push_back(fresh[i]);
      end
    end
    n_pending <= expected_words.size();
    n_fail    <= fails;
    n_checked <= checked;
    n_done    <= done_seen;
  end

endmodule

// ===== tb/tb_icy_metadata_demux.sv =====
// Top of the ICY metadata demux testbench: clock, reset, stream and APB stimulus,
// result pop pacing and the verdict. Depends on imd_pkg, icy_metadata_demux and
// imd_stream_checker, which predicts and compares every output word.
`timescale 1ns / 100ps
module tb_icy_metadata_demux;
  import imd_pkg::*;

  localparam logic [1:0]           ADDR_AUDIO_INTERVAL = 2'd0;
  localparam int                   CYCLE_LIMIT         = 400000;
  localparam int                   DRAIN_CYCLES        = 10;
  localparam int                   HOLD_CYCLES         = 100;
  localparam int                   ITEM_TARGET         = 230;
  localparam logic [8*KEY_LEN-1:0] TITLE_KEY           = "streamtitle='";
  localparam logic [8*16-1:0]      FIRST_BLOCK         = "StReAmTiTlE='a'b";

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [1:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  in_stream_byte = '0;
  logic        pop            = 1'b0;
  logic        empty;
  logic [1:0]  out_kind;
  logic [7:0]  out_data;
  logic        out_last_of_run;

  logic        jitter_on      = 1'b1;
  logic        hold_req       = 1'b0;
  logic        hold_done      = 1'b0;
  int          hold_left      = 0;
  int          cycles         = 0;
  int          sent           = 0;
  int          settings       = 0;
  int          n_pending;
  int          n_fail;
  int          n_checked;
  int          n_done;

  always #5 clk = ~clk;

  icy_metadata_demux dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .in_stream_byte(in_stream_byte),
    .pop(pop), .empty(empty), .out_kind(out_kind), .out_data(out_data),
    .out_last_of_run(out_last_of_run)
  );

  imd_stream_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pwdata(pwdata), .pready(pready),
    .push(push), .full(full), .in_stream_byte(in_stream_byte),
    .pop(pop), .empty(empty), .out_kind(out_kind), .out_data(out_data),
    .out_last_of_run(out_last_of_run),
    .n_pending(n_pending), .n_fail(n_fail), .n_checked(n_checked), .n_done(n_done)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      pop       <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      pop <= !(jitter_on && $urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $error("watchdog expired after %0d cycles, %0d words outstanding", cycles, n_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] noise_char(input bit allow_nul);
    case ($urandom_range(7))
      0: return allow_nul ? CH_NUL : 8'h73;
      1: return CH_QUOTE;
      2: return CH_SEMI;
      3: return 8'h53;
      4: return 8'h74;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] title_char();
    case ($urandom_range(5))
      0: return CH_QUOTE;
      1: return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] value);
    while (jitter_on && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_stream_byte <= value;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic send_audio(input int count);
    repeat (count) begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] value);
    settle();
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= ADDR_AUDIO_INTERVAL;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  task automatic send_meta_block(input logic [7:0] len_code, input bit cut_short);
    logic [7:0] text[$];
    logic [7:0] ch;
    int         size;
    int         stop;
    size     = int'(len_code) * 16;
    stop     = cut_short ? $urandom_range(1, size - 1) : size;
    if ($urandom_range(3) != 0) begin
      repeat ($urandom_range(0, 3)) text.push_back(noise_char(1'b0));
      for (int i = 0; i < KEY_LEN; i++) begin
        ch = TITLE_KEY[8*(KEY_LEN-1-i) +: 8];
        if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(1) == 1) ch = ch - 8'd32;
        text.push_back(ch);
      end
      repeat ($urandom_range(0, 12)) text.push_back(title_char());
      case ($urandom_range(4))
        0: begin
          text.push_back(CH_QUOTE);
          text.push_back(CH_SEMI);
        end
        1: begin
          text.push_back(CH_QUOTE);
          text.push_back(CH_NUL);
        end
        2: begin
          while (text.size() < size - 1) text.push_back(title_char());
          text.push_back(CH_QUOTE);
        end
        3: text.push_back(CH_NUL);
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(0, size)) text.push_back(noise_char(1'b1));
    end
    for (int i = 0; i < stop; i++) begin
      if (i < text.size()) ch = text[i];
      else ch = ($urandom_range(3) == 0) ? noise_char(1'b1) : CH_NUL;
      send_byte(ch);
    end
  endtask

  initial begin
    logic [15:0] iv;
    logic [7:0]  len_code;
    int          phase_no;
    int          frames;
    int          pick;
    phase_no       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through at reset, longest interval, then one framed block ending
    // in a held quote followed by a title byte
    send_byte(8'h00);
    send_byte(8'hFF);
    write_interval(16'hFFFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    write_interval(16'd1);
    send_byte(8'h3C);
    send_byte(CH_NUL);
    send_byte(8'hC3);
    send_byte(8'h01);
    for (int i = 0; i < 16; i++) send_byte(FIRST_BLOCK[8*(15-i) +: 8]);

    while (sent < ITEM_TARGET) begin
      if (phase_no == 0) begin
        iv = '0;
      end else begin
        case ($urandom_range(9))
          0: iv = '0;
          1: iv = 16'hFFFF;
          2: iv = 16'($urandom_range(41, 65534));
          3, 4: iv = 16'd1;
          default: iv = 16'($urandom_range(2, 6));
        endcase
      end
      write_interval(iv);
      jitter_on <= (phase_no != 1 && phase_no != 2);
      if (phase_no == 0) hold_req <= 1'b1;
      if (iv == 0 || iv > 40) begin
        send_audio($urandom_range(20, 40));
      end else begin
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames && sent < ITEM_TARGET; f++) begin
          send_audio(iv);
          pick = $urandom_range(29);
          if (pick == 0) begin
            send_byte(CH_NUL);
          end else begin
            len_code = 8'($urandom_range(1, 3));
            send_byte(len_code);
            send_meta_block(len_code, f == frames - 1 && $urandom_range(5) == 0);
          end
        end
      end
      phase_no++;
    end

    settle();
    $display("Sent %0d stream bytes under %0d interval settings in %0d cycles.",
             sent, settings, cycles);
    $display("Compared %0d result words, %0d of them title completions.", n_checked, n_done);
    if (n_fail == 0 && n_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
